/* sv/csr_sparse_matrix_vector_multiply_top_assert.svh */
// assertion macros for the csr spmv block
// included by the modules that check their own logic; no other dependencies
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CSP_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csp assertion failed");
`define CSP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csp assertion failed");
`else
`define CSP_ASSERT_IMPL(name, clk, rst, ante, cons)
`define CSP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* sv/csp_pkg.sv */
// types and constants shared by the csr spmv block
// no dependencies
`default_nettype none

package csp_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NONZERO = 2'd1;
  localparam logic [1:0] OP_EMPTY   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam int INDEX_W      = 10;
  localparam int VALUE_W      = 32;
  localparam int ROW_NUMBER_W = 16;
  localparam int ACC_W        = 64;
  localparam int Q_FRAC       = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  localparam logic signed [VALUE_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] SUM_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]   ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0]   ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_MAC,
    CMD_EMPTY,
    CMD_RESTART
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
  } in_item_t;

  typedef struct packed {
    logic [ROW_NUMBER_W-1:0]   row_number;
    logic signed [VALUE_W-1:0] row_sum;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      in_range;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/csr_sparse_matrix_vector_multiply_top.sv */
// csr sparse matrix times dense vector; built from csp_pkg, csp_front, csp_queue, csp_back
// a row-ending word goes through the queue slot written at acceptance, then the store read,
//   multiply, accumulate and clamp registers before its result shows;
//   throughput one word per cycle while the result register is empty or taken, set by the
//   single-port vector store and the multiply-accumulate loop
// reset clears the row accumulator, row counter, queue and valid flags; the vector store
//   keeps its contents and needs no clearing pass
`default_nettype none

module csr_sparse_matrix_vector_multiply_top #(
  parameter int VECTOR_DEPTH   = 1024,
  parameter int ROW_COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  csp_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output csp_pkg::out_item_t result
);

  logic          queue_full;
  logic          push;
  csp_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  csp_pkg::cmd_t head;

  csp_front #(
    .VECTOR_DEPTH(VECTOR_DEPTH)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .queue_full(queue_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  csp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  csp_back #(
    .VECTOR_DEPTH  (VECTOR_DEPTH),
    .ROW_COUNT_BITS(ROW_COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (head_valid),
    .cmd         (head),
    .cmd_pop     (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

/* sv/csp_front.sv */
// front end: accepts input words and turns them into queue commands
// depends on csp_pkg
`default_nettype none

module csp_front #(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic              item_valid,
  output logic              item_ready,
  input  csp_pkg::in_item_t item,
  input  logic              queue_full,
  output logic              push,
  output csp_pkg::cmd_t     cmd
);

  assign item_ready = !queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    cmd          = '0;
    cmd.index    = item.index;
    cmd.value    = item.value;
    cmd.row_end  = item.row_end;
    cmd.in_range = 32'(item.index) < 32'(VECTOR_DEPTH);
    case (item.opcode)
      csp_pkg::OP_LOAD:    cmd.kind = csp_pkg::CMD_LOAD;
      csp_pkg::OP_NONZERO: cmd.kind = csp_pkg::CMD_MAC;
      csp_pkg::OP_EMPTY:   cmd.kind = csp_pkg::CMD_EMPTY;
      csp_pkg::OP_RESTART: cmd.kind = csp_pkg::CMD_RESTART;
      default:             cmd.kind = csp_pkg::CMD_RESTART;
    endcase
  end

endmodule

`default_nettype wire

/* sv/csp_queue.sv */
// short command queue between front and back end
// depends on csp_pkg and the assertion macro header
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"

module csp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output csp_pkg::cmd_t head
);

  csp_pkg::cmd_t                     slots [csp_pkg::QUEUE_DEPTH];
  logic [csp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [csp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [csp_pkg::QUEUE_CNT_W-1:0] count;

  assign full       = count == csp_pkg::QUEUE_CNT_W'(csp_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `CSP_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, pop, count != '0)
  `CSP_ASSERT_IMPL(a_count_bounded, clk, rst, 1'b1, count <= csp_pkg::QUEUE_CNT_W'(csp_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

/* sv/csp_back.sv */
// back end: vector store, multiplier, row accumulator and result register
// depends on csp_pkg and the assertion macro header
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"

module csp_back #(
  parameter int VECTOR_DEPTH   = 1024,
  parameter int ROW_COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  csp_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               result_valid,
  input  logic               result_ready,
  output csp_pkg::out_item_t result
);

  localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  logic [csp_pkg::VALUE_W-1:0] vmem [VECTOR_DEPTH];

  logic adv;
  assign adv     = !result_valid || result_ready;
  assign cmd_pop = adv && cmd_valid;

  // stage 1: vector store access
  logic                        s1_valid;
  csp_pkg::cmd_t               s1_cmd;
  logic [csp_pkg::VALUE_W-1:0] s1_elem;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cmd_valid && cmd.kind == csp_pkg::CMD_LOAD && cmd.in_range) begin
        vmem[ADDR_W'(cmd.index)] <= cmd.value;
      end
      s1_elem <= vmem[ADDR_W'(cmd.index)];
      s1_cmd  <= cmd;
    end
  end

  // stage 2: product
  logic                               s2_valid;
  csp_pkg::cmd_kind_t                 s2_kind;
  logic                               s2_row_end;
  logic signed [csp_pkg::ACC_W-1:0]   s2_prod;
  logic signed [csp_pkg::VALUE_W-1:0] mac_elem;
  logic signed [csp_pkg::ACC_W-1:0]   prod;

  always_comb begin
    mac_elem = s1_cmd.in_range ? $signed(s1_elem) : '0;
    prod     = csp_pkg::ACC_W'(s1_cmd.value) * csp_pkg::ACC_W'(mac_elem);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod    <= prod;
      s2_kind    <= s1_cmd.kind;
      s2_row_end <= s1_cmd.row_end;
    end
  end

  // stage 3: row accumulator
  logic signed [csp_pkg::ACC_W-1:0] acc;
  logic [ROW_COUNT_BITS-1:0]        row_cnt;
  logic signed [csp_pkg::ACC_W-1:0] addend;
  logic signed [csp_pkg::ACC_W-1:0] acc_sum;
  logic signed [csp_pkg::ACC_W-1:0] acc_next;
  logic                             acc_ovf;
  logic                             s3_valid;
  logic signed [csp_pkg::ACC_W-1:0] s3_acc;
  logic [csp_pkg::ROW_NUMBER_W-1:0] s3_row;

  always_comb begin
    addend   = s2_prod >>> csp_pkg::Q_FRAC;
    acc_sum  = acc + addend;
    acc_ovf  = (acc[csp_pkg::ACC_W-1] == addend[csp_pkg::ACC_W-1]) &&
               (acc_sum[csp_pkg::ACC_W-1] != acc[csp_pkg::ACC_W-1]);
    acc_next = acc_ovf ? (acc[csp_pkg::ACC_W-1] ? csp_pkg::ACC_MIN : csp_pkg::ACC_MAX)
                       : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      acc      <= '0;
      row_cnt  <= '0;
    end else if (adv) begin
      s1_valid <= cmd_valid;
      s2_valid <= s1_valid;
      s3_valid <= 1'b0;
      if (s2_valid) begin
        case (s2_kind)
          csp_pkg::CMD_MAC: begin
            if (s2_row_end) begin
              s3_valid <= 1'b1;
              row_cnt  <= row_cnt + ROW_COUNT_BITS'(1);
              acc      <= '0;
            end else begin
              acc <= acc_next;
            end
          end
          csp_pkg::CMD_EMPTY: begin
            s3_valid <= 1'b1;
            row_cnt  <= row_cnt + ROW_COUNT_BITS'(1);
            acc      <= '0;
          end
          csp_pkg::CMD_RESTART: begin
            row_cnt <= '0;
            acc     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      s3_acc <= (s2_kind == csp_pkg::CMD_MAC) ? acc_next : '0;
      s3_row <= csp_pkg::ROW_NUMBER_W'(row_cnt);
    end
  end

  // stage 4: clamp into the result register
  logic fits;
  assign fits = (&s3_acc[csp_pkg::ACC_W-1:csp_pkg::VALUE_W-1]) ||
                !(|s3_acc[csp_pkg::ACC_W-1:csp_pkg::VALUE_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid) begin
      result.row_number <= s3_row;
      result.saturated  <= !fits;
      if (fits) begin
        result.row_sum <= s3_acc[csp_pkg::VALUE_W-1:0];
      end else begin
        result.row_sum <= s3_acc[csp_pkg::ACC_W-1] ? csp_pkg::SUM_MIN : csp_pkg::SUM_MAX;
      end
    end
  end

  `CSP_ASSERT_NEXT(a_restart_clears, clk, rst, s2_valid && adv && s2_kind == csp_pkg::CMD_RESTART, acc == '0 && row_cnt == '0)
  `CSP_ASSERT_NEXT(a_row_reaches_output, clk, rst, s3_valid && adv, result_valid)
  `CSP_ASSERT_IMPL(a_saturated_is_clipped, clk, rst, result_valid && result.saturated, result.row_sum == csp_pkg::SUM_MAX || result.row_sum == csp_pkg::SUM_MIN)

endmodule

`default_nettype wire
